[design/gray_code_pixel_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// Gray code pixel decoder assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef GRAY_CODE_PIXEL_DECODER_UNIT_MACROS_SVH
`define GRAY_CODE_PIXEL_DECODER_UNIT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define GCPD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also covers reset
`define GCPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gcpd_pkg.sv]
// ----------------------------------------------------------------------------
// Gray code pixel decoder package
// Register codes, opcodes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gcpd_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int DIM_CMP_W   = 13;
  localparam int FRAME_CMP_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECODE_MODE   = 3'd0,
    REG_BIT_THRESHOLD = 3'd1,
    REG_MIN_CONTRAST  = 3'd2,
    REG_PROJ_WIDTH    = 3'd3,
    REG_PROJ_HEIGHT   = 3'd4,
    REG_CAM_WIDTH     = 3'd5,
    REG_CAM_HEIGHT    = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic {
    MODE_THRESHOLD = 1'b0,
    MODE_ROBUST    = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [8:0]         thr;
    logic signed [9:0]  contrast;
    logic [11:0]        proj_w;
    logic [11:0]        proj_h;
    logic [9:0]         cam_w;
    logic [9:0]         cam_h;
    logic [4:0]         col_bits;
    logic [4:0]         row_bits;
    logic [5:0]         code_bits;
    logic [6:0]         last_frame;
  } cfg_t;

endpackage

`default_nettype wire

[design/gcpd_ram.sv]
// ----------------------------------------------------------------------------
// Gray code pixel decoder RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gcpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/gcpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Gray code pixel decoder configuration registers
// Register file with derived code bit counts, clamped camera size and
// sequence length.
// ----------------------------------------------------------------------------
`default_nettype none

module gcpd_cfg_regs
  import gcpd_pkg::*;
#(
  parameter int MAX_CAM_WIDTH  = 512,
  parameter int MAX_CAM_HEIGHT = 512,
  parameter int MAX_CODE_BITS  = 11
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  function automatic logic [4:0] code_bits(logic [11:0] n);
    logic [4:0] b;
    b = 5'(MAX_CODE_BITS);
    for (int k = MAX_CODE_BITS - 1; k >= 0; k--) begin
      if (17'(n) <= (17'd1 << k)) begin
        b = 5'(k);
      end
    end
    return b;
  endfunction

  function automatic logic [9:0] clamp_dim(logic [9:0] v, int unsigned maxv);
    logic [9:0] r;
    if (v == 10'd0) begin
      r = 10'd1;
    end else if (DIM_CMP_W'(v) > DIM_CMP_W'(maxv)) begin
      r = 10'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  mode_e             mode_q, mode_d;
  logic [8:0]        thr_q, thr_d;
  logic signed [9:0] contrast_q, contrast_d;
  logic [11:0]       proj_w_q, proj_w_d;
  logic [11:0]       proj_h_q, proj_h_d;
  logic [9:0]        cam_w_q, cam_w_d;
  logic [9:0]        cam_h_q, cam_h_d;
  logic [4:0]        col_bits_q, col_bits_d;
  logic [4:0]        row_bits_q, row_bits_d;
  logic [5:0]        nbits;
  logic [6:0]        last_frame;

  always_comb begin
    mode_d     = mode_q;
    thr_d      = thr_q;
    contrast_d = contrast_q;
    proj_w_d   = proj_w_q;
    proj_h_d   = proj_h_q;
    cam_w_d    = cam_w_q;
    cam_h_d    = cam_h_q;
    col_bits_d = col_bits_q;
    row_bits_d = row_bits_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DECODE_MODE:   mode_d     = mode_e'(cfg_wdata_i[0]);
        REG_BIT_THRESHOLD: thr_d      = cfg_wdata_i[8:0];
        REG_MIN_CONTRAST:  contrast_d = signed'(cfg_wdata_i[9:0]);
        REG_PROJ_WIDTH: begin
          proj_w_d   = cfg_wdata_i;
          col_bits_d = code_bits(cfg_wdata_i);
        end
        REG_PROJ_HEIGHT: begin
          proj_h_d   = cfg_wdata_i;
          row_bits_d = code_bits(cfg_wdata_i);
        end
        REG_CAM_WIDTH:     cam_w_d = clamp_dim(cfg_wdata_i[9:0], MAX_CAM_WIDTH);
        REG_CAM_HEIGHT:    cam_h_d = clamp_dim(cfg_wdata_i[9:0], MAX_CAM_HEIGHT);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_THRESHOLD;
      thr_q      <= 9'd128;
      contrast_q <= '0;
      proj_w_q   <= 12'd1024;
      proj_h_q   <= 12'd768;
      cam_w_q    <= clamp_dim(10'd512, MAX_CAM_WIDTH);
      cam_h_q    <= clamp_dim(10'd512, MAX_CAM_HEIGHT);
      col_bits_q <= code_bits(12'd1024);
      row_bits_q <= code_bits(12'd768);
    end else begin
      mode_q     <= mode_d;
      thr_q      <= thr_d;
      contrast_q <= contrast_d;
      proj_w_q   <= proj_w_d;
      proj_h_q   <= proj_h_d;
      cam_w_q    <= cam_w_d;
      cam_h_q    <= cam_h_d;
      col_bits_q <= col_bits_d;
      row_bits_q <= row_bits_d;
    end
  end

  always_comb begin
    nbits = 6'(col_bits_q) + 6'(row_bits_q);
    if (mode_q == MODE_ROBUST) begin
      last_frame = {nbits, 1'b1};
    end else if (nbits == 6'd0) begin
      last_frame = '0;
    end else begin
      last_frame = 7'(nbits) - 7'd1;
    end
  end

  always_comb begin
    cfg_o.mode       = mode_q;
    cfg_o.thr        = thr_q;
    cfg_o.contrast   = contrast_q;
    cfg_o.proj_w     = proj_w_q;
    cfg_o.proj_h     = proj_h_q;
    cfg_o.cam_w      = cam_w_q;
    cfg_o.cam_h      = cam_h_q;
    cfg_o.col_bits   = col_bits_q;
    cfg_o.row_bits   = row_bits_q;
    cfg_o.code_bits  = nbits;
    cfg_o.last_frame = last_frame;
  end

endmodule

`default_nettype wire

[design/gcpd_raster.sv]
// ----------------------------------------------------------------------------
// Gray code pixel decoder raster tracker
// Camera position and frame counter, with pixel store address.
// ----------------------------------------------------------------------------
`default_nettype none

module gcpd_raster
  import gcpd_pkg::*;
#(
  parameter int MAX_CAM_WIDTH  = 512,
  parameter int MAX_CAM_HEIGHT = 512,
  parameter int MAX_CODE_BITS  = 11,
  localparam int XW = $clog2(MAX_CAM_WIDTH),
  localparam int YW = $clog2(MAX_CAM_HEIGHT),
  localparam int FW = $clog2(2 + 4 * MAX_CODE_BITS),
  localparam int AW = $clog2(MAX_CAM_WIDTH * MAX_CAM_HEIGHT)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          pix_i,
  input  wire logic          clear_i,
  output logic [XW-1:0]      x_o,
  output logic [YW-1:0]      y_o,
  output logic [FW-1:0]      f_o,
  output logic               last_o,
  output logic [AW-1:0]      addr_o
);

  logic [XW-1:0] rx_q, rx_d;
  logic [YW-1:0] ry_q, ry_d;
  logic [FW-1:0] frame_q, frame_d;
  logic [XW-1:0] x_eff;
  logic [YW-1:0] y_eff;
  logic [FW-1:0] f_eff;
  logic          is_last;
  logic          x_end;
  logic          y_end;

  always_comb begin
    x_eff = (DIM_CMP_W'(rx_q) >= DIM_CMP_W'(cfg_i.cam_w)) ? XW'(cfg_i.cam_w - 10'd1) : rx_q;
    y_eff = (DIM_CMP_W'(ry_q) >= DIM_CMP_W'(cfg_i.cam_h)) ? YW'(cfg_i.cam_h - 10'd1) : ry_q;
    f_eff = (FRAME_CMP_W'(frame_q) > cfg_i.last_frame) ? FW'(cfg_i.last_frame) : frame_q;
    is_last = (FRAME_CMP_W'(f_eff) == cfg_i.last_frame);
    x_end = (DIM_CMP_W'(x_eff) + DIM_CMP_W'(1)) >= DIM_CMP_W'(cfg_i.cam_w);
    y_end = (DIM_CMP_W'(y_eff) + DIM_CMP_W'(1)) >= DIM_CMP_W'(cfg_i.cam_h);
  end

  always_comb begin
    rx_d    = rx_q;
    ry_d    = ry_q;
    frame_d = frame_q;
    if (clear_i) begin
      rx_d    = '0;
      ry_d    = '0;
      frame_d = '0;
    end else if (pix_i) begin
      if (x_end) begin
        rx_d = '0;
        if (y_end) begin
          ry_d    = '0;
          frame_d = is_last ? '0 : f_eff + FW'(1);
        end else begin
          ry_d = y_eff + YW'(1);
        end
      end else begin
        rx_d = x_eff + XW'(1);
        ry_d = y_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q    <= '0;
      ry_q    <= '0;
      frame_q <= '0;
    end else begin
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      frame_q <= frame_d;
    end
  end

  assign x_o    = x_eff;
  assign y_o    = y_eff;
  assign f_o    = f_eff;
  assign last_o = is_last;
  assign addr_o = AW'(y_eff) * AW'(MAX_CAM_WIDTH) + AW'(x_eff);

endmodule

`default_nettype wire

[design/gcpd_decode.sv]
// ----------------------------------------------------------------------------
// Gray code pixel decoder bit update
// Updates one pixel entry for the current frame and converts the finished
// codes to binary with the projector range check.
// ----------------------------------------------------------------------------
`default_nettype none

module gcpd_decode
  import gcpd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 11,
  localparam int CW = MAX_CODE_BITS,
  localparam int FW = $clog2(2 + 4 * MAX_CODE_BITS),
  localparam int EW = PIX_W + 1 + 2 * CW
) (
  input  wire cfg_t            cfg_i,
  input  wire logic [FW-1:0]   f_i,
  input  wire logic            last_i,
  input  wire logic [PIX_W-1:0] pix_i,
  input  wire logic [EW-1:0]   entry_i,
  output logic      [EW-1:0]   entry_o,
  output logic                 match_o,
  output logic      [CW-1:0]   proj_x_o,
  output logic      [CW-1:0]   proj_y_o
);

  localparam int MASK_BIT = PIX_W;
  localparam int COL_LO   = PIX_W + 1;
  localparam int ROW_LO   = PIX_W + 1 + CW;
  localparam int GS       = $clog2(CW);
  localparam int PCW      = (CW > 12) ? CW : 12;

  function automatic logic [CW-1:0] gray_to_bin(logic [CW-1:0] g);
    logic [CW-1:0] b;
    b = g;
    for (int s = 0; s < GS; s++) begin
      b = b ^ (b >> (1 << s));
    end
    return b;
  endfunction

  logic [PIX_W-1:0]       held;
  logic                   mask;
  logic [CW-1:0]          col;
  logic [CW-1:0]          row;
  logic [FRAME_CMP_W-1:0] ff;
  logic [FRAME_CMP_W-1:0] kk;
  logic [FRAME_CMP_W-1:0] cbe;
  logic [FRAME_CMP_W-1:0] rbe;
  logic                   set_en;
  logic                   bit_on;
  logic signed [9:0]      diff;
  logic                   lit;

  always_comb begin
    held   = entry_i[PIX_W-1:0];
    mask   = entry_i[MASK_BIT];
    col    = entry_i[COL_LO +: CW];
    row    = entry_i[ROW_LO +: CW];
    ff     = FRAME_CMP_W'(f_i);
    kk     = '0;
    cbe    = FRAME_CMP_W'(cfg_i.col_bits);
    rbe    = FRAME_CMP_W'(cfg_i.row_bits);
    set_en = 1'b0;
    bit_on = 1'b0;
    diff   = signed'({2'b00, held}) - signed'({2'b00, pix_i});

    if (cfg_i.mode == MODE_THRESHOLD) begin
      if (ff == '0) begin
        col = '0;
        row = '0;
      end
      set_en = (cfg_i.code_bits != '0);
      kk     = ff;
      bit_on = ({1'b0, pix_i} >= cfg_i.thr);
    end else if (ff == FRAME_CMP_W'(0)) begin
      held = pix_i;
    end else if (ff == FRAME_CMP_W'(1)) begin
      mask = (diff >= cfg_i.contrast);
      col  = '0;
      row  = '0;
    end else if (!ff[0]) begin
      held = pix_i;
    end else begin
      set_en = 1'b1;
      kk     = (ff - FRAME_CMP_W'(3)) >> 1;
      bit_on = (held > pix_i);
    end

    if (set_en && bit_on) begin
      if (kk < cbe) begin
        col = col | (CW'(1) << (cbe - FRAME_CMP_W'(1) - kk));
      end else if ((kk - cbe) < rbe) begin
        row = row | (CW'(1) << (rbe - FRAME_CMP_W'(1) - (kk - cbe)));
      end
    end
  end

  always_comb begin
    entry_o  = {row, col, mask, held};
    proj_x_o = gray_to_bin(col);
    proj_y_o = gray_to_bin(row);
    lit      = (cfg_i.mode == MODE_THRESHOLD) || mask;
    match_o  = last_i && lit
             && (PCW'(proj_x_o) < PCW'(cfg_i.proj_w))
             && (PCW'(proj_y_o) < PCW'(cfg_i.proj_h));
  end

endmodule

`default_nettype wire

[design/gray_code_pixel_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Gray code pixel decoder unit
// Per-pixel structured-light Gray code decoder over a camera raster stream.
//
// Input stream: tuser carries the opcode (pixel or clear), tdata the 8-bit
// sample. Samples come in raster order, one frame after another. Output
// stream: one transfer per decoded pixel on the last frame of the sequence.
// Configuration: plain write port, written while the block is idle.
// Throughput is one input transfer per cycle unless the receiver stalls.
// A result goes through the decode stage and the output register. The pixel
// store is read at accept and written as the item leaves the decode stage,
// with forwarding between back-to-back items on one pixel.
// Reset sets position and frame to zero and loads the register defaults;
// the pixel store holds no defined data until its first frame writes it,
// so reset takes no clearing pass. A clear transfer gives no result. When
// the receiver stalls, the result holds in the output register, one more
// item is taken into the decode stage, and tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_code_pixel_decoder_unit
  import gcpd_pkg::*;
#(
  parameter int MAX_CAM_WIDTH  = 512,
  parameter int MAX_CAM_HEIGHT = 512,
  parameter int MAX_CODE_BITS  = 11,
  localparam int XW    = $clog2(MAX_CAM_WIDTH),
  localparam int YW    = $clog2(MAX_CAM_HEIGHT),
  localparam int CW    = MAX_CODE_BITS,
  localparam int OUT_W = ((XW + YW + 2 * CW + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [PIX_W-1:0]      s_axis_tdata_i,  // pixel_value
  input  wire logic                  s_axis_tuser_i,  // opcode
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [OUT_W-1:0]      m_axis_tdata_o   // cam_x, cam_y, proj_x, proj_y
);

  localparam int FW    = $clog2(2 + 4 * MAX_CODE_BITS);
  localparam int AW    = $clog2(MAX_CAM_WIDTH * MAX_CAM_HEIGHT);
  localparam int EW    = PIX_W + 1 + 2 * CW;
  localparam int DEPTH = MAX_CAM_WIDTH * MAX_CAM_HEIGHT;

  cfg_t cfg;

  logic          accept;
  logic          pix_acc;
  logic          clr_acc;
  logic          adv;

  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;
  logic [FW-1:0] cur_f;
  logic          cur_last;
  logic [AW-1:0] cur_addr;

  logic             s1_valid_q, s1_valid_d;
  logic [XW-1:0]    s1_x_q;
  logic [YW-1:0]    s1_y_q;
  logic [FW-1:0]    s1_f_q;
  logic             s1_last_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]    s1_addr_q;
  logic             byp_q;
  logic [EW-1:0]    byp_data_q;

  logic [EW-1:0] rd_entry;
  logic [EW-1:0] old_entry;
  logic [EW-1:0] new_entry;
  logic          match;
  logic [CW-1:0] proj_x;
  logic [CW-1:0] proj_y;

  logic          out_valid_q, out_valid_d;
  logic [XW-1:0] cam_x_q;
  logic [YW-1:0] cam_y_q;
  logic [CW-1:0] proj_x_q;
  logic [CW-1:0] proj_y_q;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pix_acc         = accept && (s_axis_tuser_i == OP_PIXEL);
  assign clr_acc         = accept && (s_axis_tuser_i == OP_CLEAR);

  gcpd_cfg_regs #(
    .MAX_CAM_WIDTH (MAX_CAM_WIDTH),
    .MAX_CAM_HEIGHT(MAX_CAM_HEIGHT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  gcpd_raster #(
    .MAX_CAM_WIDTH (MAX_CAM_WIDTH),
    .MAX_CAM_HEIGHT(MAX_CAM_HEIGHT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_raster (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix_acc),
    .clear_i(clr_acc),
    .x_o    (cur_x),
    .y_o    (cur_y),
    .f_o    (cur_f),
    .last_o (cur_last),
    .addr_o (cur_addr)
  );

  gcpd_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q && adv),
    .waddr_i(s1_addr_q),
    .wdata_i(new_entry),
    .re_i   (pix_acc),
    .raddr_i(cur_addr),
    .rdata_o(rd_entry)
  );

  assign old_entry = byp_q ? byp_data_q : rd_entry;

  gcpd_decode #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_decode (
    .cfg_i   (cfg),
    .f_i     (s1_f_q),
    .last_i  (s1_last_q),
    .pix_i   (s1_pix_q),
    .entry_i (old_entry),
    .entry_o (new_entry),
    .match_o (match),
    .proj_x_o(proj_x),
    .proj_y_o(proj_y)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = s1_valid_q && match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_x_q     <= cur_x;
      s1_y_q     <= cur_y;
      s1_f_q     <= cur_f;
      s1_last_q  <= cur_last;
      s1_pix_q   <= s_axis_tdata_i;
      s1_addr_q  <= cur_addr;
      byp_q      <= s1_valid_q && (s1_addr_q == cur_addr);
      byp_data_q <= new_entry;
    end
    if (s1_valid_q && adv && match) begin
      cam_x_q  <= s1_x_q;
      cam_y_q  <= s1_y_q;
      proj_x_q <= proj_x;
      proj_y_q <= proj_y;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({proj_y_q, proj_x_q, cam_y_q, cam_x_q});

endmodule

`default_nettype wire

[design/gcpd_checker.sv]
// ----------------------------------------------------------------------------
// Gray code pixel decoder checker
// Port-level checks on result timing and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gray_code_pixel_decoder_unit_macros.svh"

module gcpd_checker
  import gcpd_pkg::*;
#(
  parameter int OUT_W = 40
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             s_axis_tuser_i,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o
);

  `GCPD_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `GCPD_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid right after reset")
  `GCPD_ASSERT(a_result_latency, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_PIXEL), 2), "result without pixel transfer two cycles earlier")
  `GCPD_ASSERT(a_drop_after_transfer, clk_i, rst_ni, $fell(m_axis_tvalid_o) |-> $past(m_axis_tready_i), "result dropped without transfer")

endmodule

bind gray_code_pixel_decoder_unit gcpd_checker #(
  .OUT_W(OUT_W)
) u_gcpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire
